// File: src/btas_pkg.sv
// Shared types, constants, microcode table and helpers for the block transfer address sequencer.
`timescale 1ns / 1ps

package btas_pkg;

  // Register list that a store with an empty list transfers instead.
  localparam logic [15:0] PC_ONLY_LIST = 16'h8000;
  // Register count that a store with an empty list moves the base by.
  localparam logic [4:0]  FULL_COUNT   = 5'd16;
  // Bytes per word transfer.
  localparam logic [31:0] WORD_BYTES   = 32'd4;
  // Number of the program counter register.
  localparam logic [3:0]  PC_INDEX     = 4'd15;

  // Microprogram counter and the steps of the program.
  typedef logic [1:0] upc_t;
  localparam upc_t UPC_IDLE = 2'd0;
  localparam upc_t UPC_CALC = 2'd1;
  localparam upc_t UPC_ADJ  = 2'd2;
  localparam upc_t UPC_EMIT = 2'd3;

  // Jump conditions; the jump is taken when the condition holds.
  typedef enum logic [1:0] {
    JC_NEVER,
    JC_NO_START,
    JC_SKIP,
    JC_MORE
  } jcond_t;

  // Datapath controls of one step.
  typedef struct packed {
    logic idle;       // Waiting for an item; latch the input ports.
    logic calc_base;  // Compute start address and writeback value.
    logic calc_adj;   // Apply mode and r15 corrections.
    logic emit;       // Issue one transfer.
  } ctrl_t;

  // One control word of the microprogram.
  typedef struct packed {
    ctrl_t  ctrl;
    jcond_t jcond;
    upc_t   target;
  } uword_t;

  // Status from the datapath that jump conditions test.
  typedef struct packed {
    logic skip;  // Item produces no transfers.
    logic more;  // Transfers remain after the current one.
  } dp_status_t;

  // Microprogram: the emit step falls through by wrapping to the idle step.
  function automatic uword_t ucode_rom(upc_t pc);
    uword_t w;
    w = '0;
    case (pc)
      UPC_IDLE: begin
        w.ctrl.idle = 1'b1;
        w.jcond     = JC_NO_START;
        w.target    = UPC_IDLE;
      end
      UPC_CALC: begin
        w.ctrl.calc_base = 1'b1;
        w.jcond          = JC_SKIP;
        w.target         = UPC_IDLE;
      end
      UPC_ADJ: begin
        w.ctrl.calc_adj = 1'b1;
        w.jcond         = JC_NEVER;
        w.target        = UPC_IDLE;
      end
      UPC_EMIT: begin
        w.ctrl.emit = 1'b1;
        w.jcond     = JC_MORE;
        w.target    = UPC_EMIT;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

  // Number of set bits in a register list.
  function automatic logic [4:0] count_ones16(logic [15:0] list);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 16; i++) begin
      n = n + {4'd0, list[i]};
    end
    return n;
  endfunction

endpackage

// File: src/btas_useq.sv
// Microprogram sequencer: step counter, control table lookup and conditional jumps.
`timescale 1ns / 1ps

module btas_useq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  btas_pkg::dp_status_t status,
  output btas_pkg::ctrl_t      ctrl,
  output logic                busy
);
  import btas_pkg::*;

  upc_t   upc_r;
  upc_t   upc_nxt;
  uword_t uw;
  logic   take;

  // Fetch the control word and pick the next step.
  always_comb begin
    uw = ucode_rom(upc_r);
    case (uw.jcond)
      JC_NEVER:    take = 1'b0;
      JC_NO_START: take = !start;
      JC_SKIP:     take = status.skip;
      JC_MORE:     take = status.more;
      default:     take = 1'b0;
    endcase
    upc_nxt = take ? uw.target : upc_r + 2'd1;
  end

  assign ctrl = uw.ctrl;
  assign busy = !uw.ctrl.idle;

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UPC_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// File: src/btas_datapath.sv
// Address datapath: operand latches, address and writeback adders, register picker, result registers.
`timescale 1ns / 1ps

module btas_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  btas_pkg::ctrl_t      ctrl,
  output btas_pkg::dp_status_t status,
  input  logic                 in_condition_passed,
  input  logic                 in_is_load,
  input  logic [15:0]          in_register_list,
  input  logic [3:0]           in_base_index,
  input  logic [31:0]          in_base_value,
  input  logic                 in_pre_index,
  input  logic                 in_up,
  input  logic                 in_write_back,
  input  logic                 in_user_bank_bit,
  output logic                 out_valid,
  output logic [31:0]          out_address,
  output logic [3:0]           out_register_index,
  output logic                 out_use_user_bank,
  output logic                 out_writeback_enable,
  output logic [31:0]          out_writeback_value,
  output logic                 out_restore_status,
  output logic                 out_last
);
  import btas_pkg::*;

  // Latched item.
  logic [15:0] list_r;
  logic        empty_r;
  logic        cond_r;
  logic        load_r;
  logic        rn15_r;
  logic        pre_r;
  logic        up_r;
  logic        user_r;
  logic        wb_en_r;
  logic        restore_r;
  logic [31:0] addr_r;
  logic [31:0] wbval_r;

  // Result registers.
  logic        out_valid_r;
  logic [31:0] out_address_r;
  logic [3:0]  out_register_index_r;
  logic        out_use_user_bank_r;
  logic        out_writeback_enable_r;
  logic [31:0] out_writeback_value_r;
  logic        out_restore_status_r;
  logic        out_last_r;

  logic [15:0] in_list_eff;
  logic        in_empty;
  logic [4:0]  n_regs;
  logic [31:0] offset;
  logic [31:0] mode_adj;
  logic [31:0] pc_adj;
  logic [15:0] list_rest;
  logic [3:0]  low_idx;

  // Empty list stands for r15 alone with a sixteen-register block.
  always_comb begin
    in_empty    = (in_register_list == '0);
    in_list_eff = in_empty ? PC_ONLY_LIST : in_register_list;
  end

  // Block size in bytes.
  always_comb begin
    n_regs = empty_r ? FULL_COUNT : count_ones16(list_r);
    offset = {25'd0, n_regs, 2'b00};
  end

  // First emitted address relative to the block start, folding in the pre-step.
  always_comb begin
    case ({up_r, pre_r})
      2'b11:   mode_adj = WORD_BYTES;
      2'b10:   mode_adj = '0;
      2'b01:   mode_adj = '0;
      2'b00:   mode_adj = WORD_BYTES;
      default: mode_adj = '0;
    endcase
    pc_adj = rn15_r ? WORD_BYTES : '0;
  end

  // Lowest listed register and what remains after it.
  always_comb begin
    low_idx = '0;
    for (int i = 15; i >= 0; i--) begin
      if (list_r[i]) begin
        low_idx = 4'(i);
      end
    end
    list_rest = list_r & (list_r - 16'd1);
  end

  assign status.skip = !cond_r || (load_r && empty_r);
  assign status.more = (list_rest != '0);

  // Item latch and address arithmetic.
  always_ff @(posedge clk) begin
    if (ctrl.idle) begin
      list_r    <= in_list_eff;
      empty_r   <= in_empty;
      cond_r    <= in_condition_passed;
      load_r    <= in_is_load;
      rn15_r    <= (in_base_index == PC_INDEX);
      pre_r     <= in_pre_index;
      up_r      <= in_up;
      user_r    <= in_is_load ? (in_user_bank_bit && !in_list_eff[15]) : in_user_bank_bit;
      wb_en_r   <= in_write_back && !(in_is_load && in_list_eff[in_base_index]);
      restore_r <= in_is_load && in_user_bank_bit && in_list_eff[15];
      addr_r    <= in_base_value;
    end else if (ctrl.calc_base) begin
      addr_r  <= up_r ? addr_r : addr_r - offset;
      wbval_r <= up_r ? addr_r + offset : addr_r - offset;
    end else if (ctrl.calc_adj) begin
      addr_r  <= addr_r + mode_adj + pc_adj;
      wbval_r <= wbval_r + pc_adj;
    end else if (ctrl.emit) begin
      addr_r <= addr_r + WORD_BYTES;
      list_r <= list_rest;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctrl.emit;
    end
  end

  // Result payload; end-of-instruction fields are zero on earlier items.
  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_address_r          <= addr_r;
      out_register_index_r   <= low_idx;
      out_use_user_bank_r    <= user_r;
      out_writeback_enable_r <= !status.more && wb_en_r;
      out_writeback_value_r  <= status.more ? '0 : wbval_r;
      out_restore_status_r   <= !status.more && restore_r;
      out_last_r             <= !status.more;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_address          = out_address_r;
  assign out_register_index   = out_register_index_r;
  assign out_use_user_bank    = out_use_user_bank_r;
  assign out_writeback_enable = out_writeback_enable_r;
  assign out_writeback_value  = out_writeback_value_r;
  assign out_restore_status   = out_restore_status_r;
  assign out_last             = out_last_r;

endmodule

// File: src/block_transfer_address_sequencer_unit.sv
// Top level of the block transfer address sequencer.
`timescale 1ns / 1ps

// Takes one load- or store-multiple instruction when start is high and busy is low, and
// issues one transfer per listed register, lowest register first, each shown for a single
// cycle with out_valid high; the receiver cannot stall, so every transfer must be taken
// when it appears. A microprogram of four steps runs each item: latch, base arithmetic,
// mode correction, then one transfer per cycle. An item keeps busy high in its base, mode
// and transfer steps (a store with an empty list has one transfer), and the transfers
// appear in the cycle after their step, the last in the cycle in which busy is already low
// again. An item that gives no transfers (condition failed, or load with an empty list)
// keeps busy high only for its base arithmetic step. The next item is taken in the idle
// cycle that follows, so the transfer step, one register a cycle, sets the rate.
module block_transfer_address_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_condition_passed,
  input  logic        in_is_load,
  input  logic [15:0] in_register_list,
  input  logic [3:0]  in_base_index,
  input  logic [31:0] in_base_value,
  input  logic        in_pre_index,
  input  logic        in_up,
  input  logic        in_write_back,
  input  logic        in_user_bank_bit,
  output logic        out_valid,
  output logic [31:0] out_address,
  output logic [3:0]  out_register_index,
  output logic        out_use_user_bank,
  output logic        out_writeback_enable,
  output logic [31:0] out_writeback_value,
  output logic        out_restore_status,
  output logic        out_last
);
  import btas_pkg::*;

  ctrl_t      ctrl;
  dp_status_t status;

  // Microprogram control.
  btas_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  // Address datapath.
  btas_datapath u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ctrl                 (ctrl),
    .status               (status),
    .in_condition_passed  (in_condition_passed),
    .in_is_load           (in_is_load),
    .in_register_list     (in_register_list),
    .in_base_index        (in_base_index),
    .in_base_value        (in_base_value),
    .in_pre_index         (in_pre_index),
    .in_up                (in_up),
    .in_write_back        (in_write_back),
    .in_user_bank_bit     (in_user_bank_bit),
    .out_valid            (out_valid),
    .out_address          (out_address),
    .out_register_index   (out_register_index),
    .out_use_user_bank    (out_use_user_bank),
    .out_writeback_enable (out_writeback_enable),
    .out_writeback_value  (out_writeback_value),
    .out_restore_status   (out_restore_status),
    .out_last             (out_last)
  );

endmodule

// File: tb/sv/block_transfer_address_sequencer_unit_tb.sv
// Self-checking testbench for the block transfer address sequencer unit.
`timescale 1ns / 1ps

module block_transfer_address_sequencer_unit_tb;
  import btas_pkg::*;

  // One load- or store-multiple instruction, plus flags that shape how it is driven.
  typedef struct {
    bit        cond;
    bit        load;
    bit [15:0] list;
    bit [3:0]  rn;
    bit [31:0] base;
    bit        pre;
    bit        up;
    bit        wb;
    bit        s;
    bit        steady;  // Present without a random gap.
    bit        drain;   // Hold off until every outstanding transfer has come back.
  } ldm_cmd_t;

  // One bus transfer as the block reports it.
  typedef struct packed {
    logic [31:0] address;
    logic [3:0]  reg_index;
    logic        user_bank;
    logic        wb_enable;
    logic [31:0] wb_value;
    logic        restore;
    logic        last;
  } xfer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_condition_passed = 1'b0;
  logic        in_is_load = 1'b0;
  logic [15:0] in_register_list = '0;
  logic [3:0]  in_base_index = '0;
  logic [31:0] in_base_value = '0;
  logic        in_pre_index = 1'b0;
  logic        in_up = 1'b0;
  logic        in_write_back = 1'b0;
  logic        in_user_bank_bit = 1'b0;
  logic        out_valid;
  logic [31:0] out_address;
  logic [3:0]  out_register_index;
  logic        out_use_user_bank;
  logic        out_writeback_enable;
  logic [31:0] out_writeback_value;
  logic        out_restore_status;
  logic        out_last;

  ldm_cmd_t ldm_pending_q[$];
  xfer_t    xfer_expect_q[$];
  int       mismatch_count = 0;

  block_transfer_address_sequencer_unit DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_condition_passed  (in_condition_passed),
    .in_is_load           (in_is_load),
    .in_register_list     (in_register_list),
    .in_base_index        (in_base_index),
    .in_base_value        (in_base_value),
    .in_pre_index         (in_pre_index),
    .in_up                (in_up),
    .in_write_back        (in_write_back),
    .in_user_bank_bit     (in_user_bank_bit),
    .out_valid            (out_valid),
    .out_address          (out_address),
    .out_register_index   (out_register_index),
    .out_use_user_bank    (out_use_user_bank),
    .out_writeback_enable (out_writeback_enable),
    .out_writeback_value  (out_writeback_value),
    .out_restore_status   (out_restore_status),
    .out_last             (out_last)
  );

  // Free-running clock.
  initial begin
    forever #2 clk = ~clk;
  end

  // Builds an instruction item with default driving flags.
  function automatic ldm_cmd_t ldm(bit cond, bit load, bit [15:0] list, bit [3:0] rn,
                                   bit [31:0] base, bit pre, bit up, bit wb, bit s);
    ldm_cmd_t c;
    c.cond   = cond;
    c.load   = load;
    c.list   = list;
    c.rn     = rn;
    c.base   = base;
    c.pre    = pre;
    c.up     = up;
    c.wb     = wb;
    c.s      = s;
    c.steady = 1'b0;
    c.drain  = 1'b0;
    return c;
  endfunction

  // Works out the transfers that one accepted instruction must produce.
  function automatic void predict_transfers(ldm_cmd_t c);
    logic [15:0] list;
    logic [31:0] span;
    logic [31:0] first_addr;
    logic [31:0] addr;
    logic [31:0] new_base;
    logic        pc_listed;
    logic        user;
    logic        restore;
    logic        wb_en;
    logic        fin;
    int          n;
    xfer_t       x;
    list = c.list;
    n = 0;
    for (int i = 0; i < 16; i++) begin
      n += list[i];
    end
    if (!c.cond) return;
    // An empty list is ignored by a load but makes a store move r15 alone.
    if (n == 0) begin
      if (c.load) return;
      list = PC_ONLY_LIST;
      n = 16;
    end
    pc_listed = list[PC_INDEX];
    user      = c.load ? (c.s && !pc_listed) : c.s;
    restore   = c.load && c.s && pc_listed;
    wb_en     = c.wb && !(c.load && list[c.rn]);
    span       = n * WORD_BYTES;
    first_addr = c.up ? c.base : c.base - span;
    new_base   = c.up ? c.base + span : first_addr;
    addr       = first_addr;
    // The pc as base reads four ahead.
    if (c.rn == PC_INDEX) begin
      addr     += WORD_BYTES;
      new_base += WORD_BYTES;
    end
    if (!c.up) begin
      if (c.pre) addr -= WORD_BYTES;
      else addr += WORD_BYTES;
    end
    for (int i = 0; i < 16; i++) begin
      if (list[i]) begin
        if (c.pre) addr += WORD_BYTES;
        fin = ((32'(list) >> (i + 1)) == 0);
        x.address   = addr;
        x.reg_index = 4'(i);
        x.user_bank = user;
        x.wb_enable = fin && wb_en;
        x.wb_value  = fin ? new_base : '0;
        x.restore   = fin && restore;
        x.last      = fin;
        xfer_expect_q.push_back(x);
        if (!c.pre) addr += WORD_BYTES;
      end
    end
  endfunction

  // Driver: presents the head of the pending queue and predicts each accepted item.
  always @(posedge clk) begin : drive_proc
    logic present;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      present = start;
      if (start && !busy) begin
        predict_transfers(ldm_pending_q.pop_front());
        present = 1'b0;
      end
      if (!present && ldm_pending_q.size() != 0) begin
        present = 1'b1;
        if (ldm_pending_q[0].drain && xfer_expect_q.size() != 0) begin
          present = 1'b0;
        end else if (!ldm_pending_q[0].steady && $urandom_range(99) < 16) begin
          present = 1'b0;
        end
      end
      if (present) begin
        in_condition_passed <= ldm_pending_q[0].cond;
        in_is_load          <= ldm_pending_q[0].load;
        in_register_list    <= ldm_pending_q[0].list;
        in_base_index       <= ldm_pending_q[0].rn;
        in_base_value       <= ldm_pending_q[0].base;
        in_pre_index        <= ldm_pending_q[0].pre;
        in_up               <= ldm_pending_q[0].up;
        in_write_back       <= ldm_pending_q[0].wb;
        in_user_bank_bit    <= ldm_pending_q[0].s;
      end
      start <= present;
    end
  end

  // Monitor: checks every strobed transfer against the oldest expectation.
  always @(posedge clk) begin : check_proc
    xfer_t seen;
    xfer_t want;
    if (rst_n && out_valid) begin
      seen = '{out_address, out_register_index, out_use_user_bank, out_writeback_enable,
               out_writeback_value, out_restore_status, out_last};
      if (xfer_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected transfer: addr=%h reg=%0d", seen.address, seen.reg_index);
        end
      end else begin
        want = xfer_expect_q.pop_front();
        if (seen.address !== want.address || seen.reg_index !== want.reg_index ||
            seen.user_bank !== want.user_bank || seen.wb_enable !== want.wb_enable ||
            seen.wb_value !== want.wb_value || seen.restore !== want.restore ||
            seen.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Transfer mismatch: exp addr=%h reg=%0d usr=%b wbe=%b wbv=%h rst=%b last=%b",
                     want.address, want.reg_index, want.user_bank, want.wb_enable,
                     want.wb_value, want.restore, want.last);
            $display("                   got addr=%h reg=%0d usr=%b wbe=%b wbv=%h rst=%b last=%b",
                     seen.address, seen.reg_index, seen.user_bank, seen.wb_enable,
                     seen.wb_value, seen.restore, seen.last);
          end
        end
      end
    end
  end

  // Stimulus, end of run and verdict.
  initial begin : stim_proc
    ldm_cmd_t c;
    int       pick;
    // Directed instructions: empty lists, full lists, all four modes, r15 as base.
    ldm_pending_q.push_back(ldm(1, 1, 16'hFFFF, 4'd0, 32'h0000_0000, 1, 1, 1, 1));
    ldm_pending_q.push_back(ldm(1, 0, 16'hFFFF, 4'd7, 32'hFFFF_FFFC, 0, 1, 1, 0));
    ldm_pending_q.push_back(ldm(0, 0, 16'h00FF, 4'd1, 32'h0000_1000, 0, 1, 1, 1));
    ldm_pending_q.push_back(ldm(0, 1, 16'hFFFF, 4'd2, 32'h0000_2000, 1, 0, 1, 1));
    ldm_pending_q.push_back(ldm(1, 1, 16'h0000, 4'd3, 32'h0000_3000, 0, 1, 1, 0));
    ldm_pending_q.push_back(ldm(1, 0, 16'h0000, 4'd3, 32'h0000_3000, 0, 1, 1, 0));
    ldm_pending_q.push_back(ldm(1, 0, 16'h0000, 4'd15, 32'h0000_4000, 1, 0, 1, 1));
    ldm_pending_q.push_back(ldm(1, 0, 16'h0000, 4'd0, 32'h0000_0000, 0, 0, 1, 0));
    ldm_pending_q.push_back(ldm(1, 0, 16'h0000, 4'd5, 32'hFFFF_FFF0, 1, 1, 1, 0));
    c = ldm(1, 1, 16'h0001, 4'd9, 32'h0000_0010, 1, 0, 1, 0);
    c.drain = 1'b1;
    ldm_pending_q.push_back(c);
    ldm_pending_q.push_back(ldm(1, 1, 16'h8000, 4'd1, 32'h8000_0000, 0, 1, 0, 1));
    ldm_pending_q.push_back(ldm(1, 1, 16'h7FFF, 4'd14, 32'h0001_0000, 1, 1, 1, 1));
    ldm_pending_q.push_back(ldm(1, 0, 16'h8001, 4'd2, 32'h0000_0100, 0, 0, 1, 1));
    ldm_pending_q.push_back(ldm(1, 1, 16'h00F0, 4'd15, 32'h0000_0200, 1, 1, 1, 0));
    ldm_pending_q.push_back(ldm(1, 1, 16'h0010, 4'd4, 32'h0000_0300, 0, 1, 1, 0));
    ldm_pending_q.push_back(ldm(1, 0, 16'h0010, 4'd4, 32'h0000_0300, 0, 1, 1, 0));
    ldm_pending_q.push_back(ldm(1, 1, 16'h8001, 4'd8, 32'h0000_1000, 0, 0, 1, 0));
    ldm_pending_q.push_back(ldm(1, 0, 16'hAAAA, 4'd6, 32'hFFFF_FFFF, 0, 1, 1, 0));
    ldm_pending_q.push_back(ldm(1, 1, 16'h5555, 4'd15, 32'h0000_0000, 1, 0, 0, 1));
    ldm_pending_q.push_back(ldm(1, 0, 16'hFFFF, 4'd15, 32'h0000_0004, 1, 0, 1, 1));
    ldm_pending_q.push_back(ldm(1, 1, 16'h0000, 4'd15, 32'hFFFF_FFFF, 1, 0, 0, 1));

    // Random instructions, mostly with a passing condition; one stretch runs without gaps.
    for (int k = 0; k < 350; k++) begin
      c = ldm($urandom_range(99) < 92, 1'($urandom_range(1)), 16'h0000,
              4'($urandom_range(15)), $urandom, 1'($urandom_range(1)),
              1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      pick = $urandom_range(9);
      case (pick)
        0: c.list = 16'h0000;
        1: c.list = 16'h0001 << $urandom_range(15);
        2: c.list = 16'hFFFF;
        3, 4, 5: c.list = 16'($urandom);
        default: c.list = 16'($urandom) & 16'($urandom);
      endcase
      pick = $urandom_range(9);
      if (pick == 0) c.base = $urandom_range(63);
      else if (pick == 1) c.base = 32'hFFFF_FFFF - $urandom_range(63);
      c.steady = (k >= 100 && k < 200);
      c.drain  = (k % 60 == 59);
      ldm_pending_q.push_back(c);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every item is accepted and every transfer has come back.
    while (ldm_pending_q.size() != 0 || start || xfer_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    if (mismatch_count == 0 && xfer_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: block_transfer_address_sequencer_unit.f
src/btas_pkg.sv
src/btas_useq.sv
src/btas_datapath.sv
src/block_transfer_address_sequencer_unit.sv
tb/sv/block_transfer_address_sequencer_unit_tb.sv
